FILE: src/mail_dot_stuffing_escaper_unit_macros.svh
// assertion macros for the mail dot-stuffing escaper
// expects clk and arst_n to be visible where the macros are used
`ifndef MAIL_DOT_STUFFING_ESCAPER_UNIT_MACROS_SVH
`define MAIL_DOT_STUFFING_ESCAPER_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define MDSE_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while in reset
`define MDSE_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/mdse_pkg.sv
// shared types and constants of the mail dot-stuffing escaper
// no dependencies
`default_nettype none

package mdse_pkg;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_DOT = 8'h2E;

	localparam int LIMIT_W  = 32;
	localparam int REMAIN_W = LIMIT_W + 1;

	// configuration register indexes
	localparam logic CFG_LIMIT_EN   = 1'b0;
	localparam logic CFG_LINE_LIMIT = 1'b1;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// one queue entry: one or two bytes to send
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two;
	} cmd_t;

	typedef struct packed {
		logic                 limit_en;
		logic [LIMIT_W-1:0]   line_limit;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

FILE: src/mdse_front.sv
// front end: keeps per-message line state and turns each item into at most one queue entry
// depends on mdse_pkg
`default_nettype none

module mdse_front
	import mdse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     take,
	input  wire in_item_t item,
	output logic          push,
	output cmd_t          cmd
);

	logic                in_header_q;
	logic [7:0]          prev_q;
	logic [REMAIN_W-1:0] lines_q;
	logic                stopped_q;
	logic                at_start_q;

	logic                is_lf;
	logic                is_cr;
	logic                hdr_next;
	logic                lines_zero;
	logic                lines_one;
	logic [REMAIN_W-1:0] lines_load;
	logic [REMAIN_W-1:0] lines_dec;
	logic                count_lf;

	always_comb begin
		is_lf = (item.byte_value == CH_LF);
		is_cr = (item.byte_value == CH_CR);
		hdr_next = in_header_q & ~((is_cr | is_lf) & (at_start_q | (prev_q == CH_LF)));
		// on the first byte the count is limit + 1, which is never zero
		lines_load = at_start_q ? ({1'b0, cfg.line_limit} + REMAIN_W'(1)) : lines_q;
		lines_dec  = at_start_q ? {1'b0, cfg.line_limit} : (lines_q - REMAIN_W'(1));
		lines_zero = at_start_q ? 1'b0 : (lines_q == '0);
		lines_one  = at_start_q ? (cfg.line_limit == '0) : (lines_q == REMAIN_W'(1));
		count_lf   = is_lf & ~hdr_next & cfg.limit_en & ~lines_zero;

		push = 1'b0;
		cmd  = '{byte0: item.byte_value, byte1: CH_LF, two: 1'b0};
		if (item.message_end) begin
			push = take & (prev_q != CH_LF);
			cmd  = '{byte0: CH_CR, byte1: CH_LF, two: 1'b1};
		end else if (!stopped_q) begin
			push = take;
			if (is_lf) begin
				if (prev_q != CH_CR) begin
					cmd = '{byte0: CH_CR, byte1: CH_LF, two: 1'b1};
				end else begin
					cmd = '{byte0: CH_LF, byte1: CH_LF, two: 1'b0};
				end
			end else if (item.byte_value == CH_DOT && prev_q == CH_LF) begin
				cmd = '{byte0: CH_DOT, byte1: CH_DOT, two: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_header_q <= 1'b1;
			prev_q      <= '0;
			lines_q     <= '0;
			stopped_q   <= 1'b0;
			at_start_q  <= 1'b1;
		end else if (take) begin
			if (item.message_end) begin
				in_header_q <= 1'b1;
				prev_q      <= '0;
				lines_q     <= '0;
				stopped_q   <= 1'b0;
				at_start_q  <= 1'b1;
			end else begin
				at_start_q <= 1'b0;
				lines_q    <= lines_load;
				if (!stopped_q) begin
					in_header_q <= hdr_next;
					if (is_lf) begin
						prev_q <= CH_LF;
						if (count_lf) begin
							lines_q <= lines_dec;
							if (lines_one) begin
								stopped_q <= 1'b1;
							end
						end
					end else begin
						prev_q <= item.byte_value;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/mdse_queue.sv
// short queue of byte commands between front and back end
// depends on mdse_pkg
`default_nettype none

module mdse_queue
	import mdse_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/mdse_back.sv
// back end: expands queue entries into output items through an output register
// depends on mdse_pkg
`default_nettype none

module mdse_back
	import mdse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_t      head,
	input  wire q_status_t status,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	logic       valid_q;
	out_item_t  item_q;
	logic       phase_q;
	logic [7:0] second_q;
	logic       load;

	assign load      = ~valid_q | out_ready;
	assign pop       = load & ~phase_q & ~status.empty;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (phase_q) begin
				item_q <= '{out_byte: second_q, last_of_run: 1'b1};
			end else begin
				item_q   <= '{out_byte: head.byte0, last_of_run: ~head.two};
				second_q <= head.byte1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			if (phase_q) begin
				valid_q <= 1'b1;
				phase_q <= 1'b0;
			end else begin
				valid_q <= ~status.empty;
				phase_q <= ~status.empty & head.two;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/mail_dot_stuffing_escaper_unit.sv
// top level of the mail dot-stuffing escaper: config registers, front, queue, back
// depends on mdse_pkg, mdse_front, mdse_queue, mdse_back and the macros header
`default_nettype none

`include "mail_dot_stuffing_escaper_unit_macros.svh"

// takes one message byte per item and sends it escaped for a line-oriented mail
// protocol: a bare lf gets a cr in front, a dot right after an lf is doubled, and an
// end item closes the message with cr lf unless the last byte sent was lf. with
// line limiting on, the header, the empty line and the set number of body lines
// pass, after which bytes are dropped until the end item. the front end accepts
// one item per cycle whenever the queue has room; the back end sends one byte per
// cycle while the receiver is ready, so a byte that expands to two (cr lf, dot dot)
// goes out as two bytes in turn and the queue absorbs the difference. sustained
// rate is one item per cycle for plain bytes while the receiver is ready, set by
// the single output register. the first result of an item is registered in the
// queue, then in the output register. write configuration only when idle;
// the line limit is sampled on the first byte of each message

module mail_dot_stuffing_escaper_unit
	import mdse_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_ready,
	input  wire in_item_t    byte_item,
	output logic             esc_valid,
	input  wire logic        esc_ready,
	output out_item_t        esc_item,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	cfg_t      cfg_q;
	logic      take;
	logic      q_push;
	cmd_t      q_cmd;
	logic      q_pop;
	cmd_t      q_head;
	q_status_t q_status;

	// configuration registers, plain write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIMIT_EN:   cfg_q.limit_en   <= cfg_wdata[0];
				CFG_LINE_LIMIT: cfg_q.line_limit <= cfg_wdata[LIMIT_W-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// an item is only taken while the queue can hold whatever it produces
	assign byte_ready = ~q_status.full;
	assign take       = byte_valid & byte_ready;

	mdse_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.item   (byte_item),
		.push   (q_push),
		.cmd    (q_cmd)
	);

	mdse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.status   (q_status)
	);

	mdse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.status    (q_status),
		.pop       (q_pop),
		.out_valid (esc_valid),
		.out_ready (esc_ready),
		.out_item  (esc_item)
	);

	// queue cannot be full and empty at once
	`MDSE_CHECK(a_queue_sane, 1'b1, !(q_status.full && q_status.empty), "queue full and empty")
	// back end only pops a filled queue
	`MDSE_CHECK(a_pop_filled, q_pop, !q_status.empty, "pop from empty queue")
	// second byte of a pair is ready straight after the first leaves
	`MDSE_CHECK_NEXT(a_pair_follows, esc_valid && esc_ready && !esc_item.last_of_run,
		esc_valid && esc_item.last_of_run, "second byte of pair missing")

endmodule

`default_nettype wire

FILE: tb/mail_dot_stuffing_escaper_unit_tb.sv
// self-checking testbench for mail_dot_stuffing_escaper_unit
// drives message bytes and end items, predicts the escaped byte stream, compares per item
// depends on mdse_pkg and the escaper rtl only
`timescale 1ns / 100ps

module mail_dot_stuffing_escaper_unit_tb;
	import mdse_pkg::*;

	localparam int PREDICT     = -1;   // row result comes from the escaper model below
	localparam int SETTLE      = 8;    // cycles allowed for a dropped byte to leave the pipe
	localparam int STALL_LIMIT = 2000; // cycles with no item moving before giving up
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 245;
	localparam out_item_t NONE = '0;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	// one line of the directed plan: either an item or a pair of register writes
	typedef struct {
		row_kind_e   kind;
		in_item_t    item;
		int          pinned;   // number of typed-in results, or PREDICT
		out_item_t   r0;
		out_item_t   r1;
		logic        en;
		logic [31:0] lim;
	} stim_row_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	in_item_t    byte_item  = '0;
	logic        esc_valid;
	logic        esc_ready  = 1'b0;
	out_item_t   esc_item;
	logic        cfg_we     = 1'b0;
	logic        cfg_index  = CFG_LIMIT_EN;
	logic [31:0] cfg_wdata  = '0;

	always #2 clk = ~clk;

	mail_dot_stuffing_escaper_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.esc_valid (esc_valid),
		.esc_ready (esc_ready),
		.esc_item  (esc_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ------------------------------------------------------------------
	// escaper model: own copy of the registers and per-message state
	// ------------------------------------------------------------------
	logic        lim_en;
	logic [31:0] line_lim;
	logic        hdr_open;
	logic [7:0]  last_sent;
	logic [32:0] lines_left;
	logic        line_stop;
	logic        msg_fresh;

	function automatic void clear_message();
		hdr_open   = 1'b1;
		last_sent  = 8'h00;
		lines_left = '0;
		line_stop  = 1'b0;
		msg_fresh  = 1'b1;
	endfunction

	// escapes one item, returns how many bytes go out (0..2)
	function automatic int escape_step(input in_item_t it, output out_item_t r0,
			output out_item_t r1);
		logic [7:0] b;
		logic [7:0] prev;
		logic       fresh;
		int         n;
		b     = it.byte_value;
		prev  = last_sent;
		fresh = msg_fresh;
		n     = 0;
		r0    = NONE;
		r1    = NONE;
		if (it.message_end) begin
			// close the last line unless it already ended in lf
			if (last_sent != CH_LF) begin
				r0 = {CH_CR, 1'b0};
				r1 = {CH_LF, 1'b1};
				n  = 2;
			end
			clear_message();
			return n;
		end
		// line limit is sampled on the first byte of every message
		if (fresh) begin
			lines_left = {1'b0, line_lim} + 33'd1;
			msg_fresh  = 1'b0;
		end
		if (line_stop)
			return 0;
		// empty line ends the header; the message start counts as a line start here
		if (hdr_open && (b == CH_CR || b == CH_LF) && (fresh || prev == CH_LF))
			hdr_open = 1'b0;
		if (b == CH_LF) begin
			if (prev != CH_CR) begin
				r0 = {CH_CR, 1'b0};
				r1 = {CH_LF, 1'b1};
				n  = 2;
			end else begin
				r0 = {CH_LF, 1'b1};
				n  = 1;
			end
			last_sent = CH_LF;
			if (!hdr_open && lim_en && lines_left != 0) begin
				lines_left = lines_left - 33'd1;
				if (lines_left == 0)
					line_stop = 1'b1;
			end
			return n;
		end
		// a dot opening a line is doubled, but not at the very start of a message
		if (b == CH_DOT && prev == CH_LF) begin
			r0        = {CH_DOT, 1'b0};
			r1        = {CH_DOT, 1'b1};
			last_sent = CH_DOT;
			return 2;
		end
		r0        = {b, 1'b1};
		last_sent = b;
		return 1;
	endfunction

	initial begin
		lim_en   = 1'b0;
		line_lim = '0;
		clear_message();
	end

	// ------------------------------------------------------------------
	// monitor: follows register writes and accepted items, checks escaped bytes
	// ------------------------------------------------------------------
	out_item_t esc_expect_q[$];
	stim_row_t pin_q[$];
	int        fail_count  = 0;
	int        live_items  = 0;
	int        n_results   = 0;
	int        n_messages  = 0;

	always @(posedge clk) begin : monitor
		out_item_t a;
		out_item_t c;
		out_item_t want;
		stim_row_t pin;
		int        n;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_LIMIT_EN)
					lim_en = cfg_wdata[0];
				else
					line_lim = cfg_wdata;
			end
			if (byte_valid && byte_ready) begin
				n = escape_step(byte_item, a, c);
				// every accepted item counts, dropped bytes included
				live_items <= live_items + 1;
				if (byte_item.message_end)
					n_messages <= n_messages + 1;
				// directed rows may carry results typed in by hand
				if (pin_q.size() != 0) begin
					pin = pin_q.pop_front();
					if (pin.pinned != PREDICT) begin
						n = pin.pinned;
						a = pin.r0;
						c = pin.r1;
					end
				end
				if (n >= 1)
					esc_expect_q.push_back(a);
				if (n >= 2)
					esc_expect_q.push_back(c);
			end
			if (esc_valid && esc_ready) begin
				n_results <= n_results + 1;
				if (esc_expect_q.size() == 0) begin
					$display("%0t: unexpected byte out: got %h last %b", $time,
						esc_item.out_byte, esc_item.last_of_run);
					fail_count++;
				end else begin
					want = esc_expect_q.pop_front();
					if (esc_item.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %h got %h", $time,
							want.out_byte, esc_item.out_byte);
						fail_count++;
					end
					if (esc_item.last_of_run !== want.last_of_run) begin
						$display("%0t: last_of_run expected %b got %b (byte %h)", $time,
							want.last_of_run, esc_item.last_of_run, want.out_byte);
						fail_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: back-pressure pattern picked at random from four modes
	// ------------------------------------------------------------------
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;

	always @(posedge clk) begin
		rx_tick++;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end else
			rx_left--;
		case (rx_mode)
		0: esc_ready <= 1'b1;                          // never stalls
		1: esc_ready <= 1'($urandom_range(0, 1));      // coin toss
		2: esc_ready <= ($urandom_range(0, 7) != 0);   // rare stalls
		default: esc_ready <= (rx_tick % 5) != 0;      // fixed one-in-five stall
		endcase
	end

	// watchdog: nothing moving on either side for too long
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (esc_valid && esc_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d bytes still expected", $time,
				STALL_LIMIT, esc_expect_q.size());
			$display("mail_dot_stuffing_escaper_unit_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sender: bursts of random length separated by random gaps
	// ------------------------------------------------------------------
	int burst_left = 0;

	task automatic send_item(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		do @(posedge clk); while (!byte_ready);
		burst_left--;
	endtask

	// let every predicted byte come out, then give dropped bytes time to drain
	task automatic wait_drained();
		byte_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (esc_expect_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both registers back to back; only used while the block is idle
	task automatic write_limits(input logic en, input logic [31:0] lim);
		logic [31:0] junk;
		junk = $urandom;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LIMIT_EN;
		cfg_wdata <= {junk[31:1], en};   // only bit 0 counts
		@(posedge clk);
		cfg_index <= CFG_LINE_LIMIT;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// random message content
	// ------------------------------------------------------------------
	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return CH_DOT;
		if (r == 1)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] noise_byte();
		int r;
		r = $urandom_range(0, 11);
		if (r < 3)
			return CH_CR;
		if (r < 6)
			return CH_LF;
		if (r < 8)
			return CH_DOT;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_byte(input logic [7:0] b);
		send_item({b, 1'b0});
	endtask

	// mostly cr lf, some bare lf, now and then a doubled cr
	task automatic send_eol();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			send_byte(CH_CR);
		else if (r == 9) begin
			send_byte(CH_CR);
			send_byte(CH_CR);
		end
		send_byte(CH_LF);
	endtask

	task automatic send_line(input int len, input bit dotted);
		if (dotted)
			send_byte(CH_DOT);
		repeat (len) send_byte(text_byte());
	endtask

	// one message: header lines, empty line, body lines, end item; or plain noise
	task automatic send_mail(input bit garbled);
		int nh;
		int nb;
		if (garbled)
			repeat ($urandom_range(1, 30)) send_byte(noise_byte());
		else begin
			nh = $urandom_range(0, 3);
			nb = $urandom_range(0, 8);
			repeat (nh) begin
				send_line($urandom_range(1, 12), $urandom_range(0, 5) == 0);
				send_eol();
			end
			send_eol();
			for (int k = 0; k < nb; k++) begin
				send_line($urandom_range(0, 15), $urandom_range(0, 2) == 0);
				// last body line sometimes left open for the end item to close
				if (k != nb - 1 || $urandom_range(0, 2) != 0)
					send_eol();
			end
		end
		send_item({8'($urandom_range(0, 255)), 1'b1});
	endtask

	// ------------------------------------------------------------------
	// directed plan
	// ------------------------------------------------------------------
	stim_row_t plan[$];

	function automatic stim_row_t item_row(input logic [7:0] b, input logic e,
			input int pin, input out_item_t r0, input out_item_t r1);
		stim_row_t row;
		row.kind   = ROW_ITEM;
		row.item   = {b, e};
		row.pinned = pin;
		row.r0     = r0;
		row.r1     = r1;
		row.en     = 1'b0;
		row.lim    = '0;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic en, input logic [31:0] lim);
		stim_row_t row;
		row        = item_row(8'h00, 1'b0, PREDICT, NONE, NONE);
		row.kind   = ROW_CFG;
		row.en     = en;
		row.lim    = lim;
		return row;
	endfunction

	initial begin : stimulus
		logic [32:0] phase_cfg[PHASES];
		int          phase_start;

		// whole message, limits as after reset
		plan.push_back(item_row(CH_DOT, 1'b0, 1, {CH_DOT, 1'b1}, NONE)); // leading dot kept single
		plan.push_back(item_row(8'h41, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(CH_LF, 1'b0, 2, {CH_CR, 1'b0}, {CH_LF, 1'b1})); // bare lf
		plan.push_back(item_row(CH_DOT, 1'b0, 2, {CH_DOT, 1'b0}, {CH_DOT, 1'b1})); // dot doubled
		plan.push_back(item_row(8'hFF, 1'b0, 1, {8'hFF, 1'b1}, NONE));
		plan.push_back(item_row(CH_CR, 1'b0, 1, {CH_CR, 1'b1}, NONE));
		plan.push_back(item_row(CH_LF, 1'b0, 1, {CH_LF, 1'b1}, NONE)); // lf after cr untouched
		plan.push_back(item_row(8'h00, 1'b0, 1, {8'h00, 1'b1}, NONE));
		plan.push_back(item_row(8'h00, 1'b1, 2, {CH_CR, 1'b0}, {CH_LF, 1'b1}));
		// header closed by cr at the message start, end item after a dot
		plan.push_back(item_row(CH_CR, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(CH_LF, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(CH_DOT, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(8'hFF, 1'b1, 2, {CH_CR, 1'b0}, {CH_LF, 1'b1}));
		// empty message still gets its line closed
		plan.push_back(item_row(8'h55, 1'b1, 2, {CH_CR, 1'b0}, {CH_LF, 1'b1}));
		// limit of zero body lines: stops right after the empty line
		plan.push_back(cfg_row(1'b1, 32'd0));
		plan.push_back(item_row(8'h48, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(CH_LF, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(CH_LF, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(8'h62, 1'b0, PREDICT, NONE, NONE));  // dropped
		plan.push_back(item_row(CH_DOT, 1'b0, PREDICT, NONE, NONE)); // dropped
		plan.push_back(item_row(8'hAA, 1'b1, PREDICT, NONE, NONE));  // nothing, last was lf
		// one body line, header empty from the start
		plan.push_back(cfg_row(1'b1, 32'd1));
		plan.push_back(item_row(CH_LF, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(8'h78, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(CH_LF, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(8'h79, 1'b0, PREDICT, NONE, NONE));
		plan.push_back(item_row(8'h00, 1'b1, PREDICT, NONE, NONE));

		// limit settings for the random part, extremes included
		phase_cfg[0] = {1'b0, 32'($urandom)};
		phase_cfg[1] = {1'b1, 32'd0};
		phase_cfg[2] = {1'b1, 32'd1};
		phase_cfg[3] = {1'b1, 32'd2};
		phase_cfg[4] = {1'b1, 32'($urandom_range(3, 9))};
		phase_cfg[5] = {1'b1, 32'hFFFF_FFFF};
		phase_cfg[6] = {1'b0, 32'hFFFF_FFFF};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_drained();
				write_limits(plan[i].en, plan[i].lim);
			end else begin
				pin_q.push_back(plan[i]);
				send_item(plan[i].item);
			end
		end
		wait_drained();

		// random messages, most well formed, some plain noise
		for (int p = 0; p < PHASES; p++) begin
			write_limits(phase_cfg[p][32], phase_cfg[p][31:0]);
			phase_start = live_items;
			while (live_items - phase_start < PHASE_ITEMS)
				send_mail($urandom_range(0, 4) == 0);
			wait_drained();
		end

		$display("escaper run: %0d items sent in %0d messages, %0d bytes checked",
			live_items, n_messages, n_results);
		$display("line limit settings: %0d random phases after %0d directed rows",
			PHASES, plan.size());
		if (fail_count == 0)
			$display("mail_dot_stuffing_escaper_unit_tb OK");
		else
			$display("mail_dot_stuffing_escaper_unit_tb NOT OK");
		$finish;
	end

endmodule
